// ===== design/aes_pkg.sv =====
// Package for the AES-128 encryption pipeline: S-box table, GF(2^8) helpers,
// round function and key schedule step. No dependencies.
`default_nettype none
package aes_pkg;

    typedef logic [127:0] t_block;
    typedef logic [7:0]   t_byte;

    localparam int NUM_ROUNDS = 10;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Byte k of a block sits in bits 127-8k downto 120-8k.
    function automatic t_byte get_byte(input t_block b, input int k);
        get_byte = b[127 - 8 * k -: 8];
    endfunction

    function automatic t_byte gf_double(input t_byte v);
        gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
    function automatic t_block round_fn(input t_block s, input t_block rk, input logic mix);
        t_byte  t [16];
        t_byte  a0, a1, a2, a3, all;
        t_block o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c * 4 + r] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[c * 4];
            a1 = t[c * 4 + 1];
            a2 = t[c * 4 + 2];
            a3 = t[c * 4 + 3];
            if (mix) begin
                all = a0 ^ a1 ^ a2 ^ a3;
                t[c * 4]     = a0 ^ all ^ gf_double(a0 ^ a1);
                t[c * 4 + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
                t[c * 4 + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
                t[c * 4 + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
        end
        for (int k = 0; k < 16; k++) begin
            o[127 - 8 * k -: 8] = t[k] ^ get_byte(rk, k);
        end
        round_fn = o;
    endfunction

    // One AES-128 key expansion step: next round key from the previous one.
    function automatic t_block key_step(input t_block k, input t_byte rcon);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ===== design/aes_key_sched.sv =====
// Round key schedule: expands the configured key into eleven registered
// round keys, one expansion step per cycle. Depends on aes_pkg.
`default_nettype none
module aes_key_sched (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire aes_pkg::t_block i_key,
    output aes_pkg::t_block      o_rk [aes_pkg::NUM_ROUNDS + 1]
);
    aes_pkg::t_block r_rk [aes_pkg::NUM_ROUNDS + 1];
    aes_pkg::t_byte  rcon [aes_pkg::NUM_ROUNDS];

    always_comb begin
        rcon[0] = 8'h01;
        for (int i = 1; i < aes_pkg::NUM_ROUNDS; i++) begin
            rcon[i] = aes_pkg::gf_double(rcon[i - 1]);
        end
    end

    // Advance one step per cycle; after a write the new keys settle in order, from r_rk[0] to the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= aes_pkg::NUM_ROUNDS; i++) r_rk[i] <= '0;
        end else begin
            r_rk[0] <= i_key;
            for (int i = 1; i <= aes_pkg::NUM_ROUNDS; i++) begin
                r_rk[i] <= aes_pkg::key_step(r_rk[i - 1], rcon[i - 1]);
            end
        end
    end

    assign o_rk = r_rk;
endmodule
`default_nettype wire

// ===== design/aes_round_stage.sv =====
// One pipeline stage holding a single AES round with its valid bit.
// Depends on aes_pkg.
`default_nettype none
module aes_round_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire aes_pkg::t_block i_state,
    input  wire aes_pkg::t_block i_rk,
    input  wire logic            i_mix,
    output logic                 o_valid,
    output aes_pkg::t_block      o_state
);
    logic            r_valid;
    aes_pkg::t_block r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= aes_pkg::round_fn(i_state, i_rk, i_mix);
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
endmodule
`default_nettype wire

// ===== design/aes128_block_encrypt_core.sv =====
// Top level of the AES-128 ECB encryption pipeline.
// Depends on aes_pkg, aes_key_sched and aes_round_stage.
`default_nettype none
// A block is accepted at any clock edge with i_start high and o_busy low. Its
// ciphertext is driven on o_cipher_* with o_done high after it has passed the
// whole path: one input register with the initial AddRoundKey, ten registered
// round stages and the output register. One block per cycle is sustained while
// o_busy is low. The receiver cannot stall, so nothing holds the pipe. The key
// is expanded by a registered schedule one round per cycle, and each round key
// reaches its stage in step with the blocks. o_busy is raised in the cycle
// after each key write, so the next block enters behind the new round keys.
module aes128_block_encrypt_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [63:0] i_block_high,
    input  wire logic [63:0] i_block_low,
    output logic             o_done,
    output logic [63:0]      o_cipher_high,
    output logic [63:0]      o_cipher_low,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [63:0]     r_key_high, r_key_low;
    logic            r_busy;
    aes_pkg::t_block rk [aes_pkg::NUM_ROUNDS + 1];
    logic            r_in_valid;
    aes_pkg::t_block r_in_state;
    logic            v [aes_pkg::NUM_ROUNDS + 1];
    aes_pkg::t_block st [aes_pkg::NUM_ROUNDS + 1];
    logic            r_done;
    aes_pkg::t_block r_out;

    assign o_busy      = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aes_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold off input in the cycle after a key write, until the first round key
    // carries the new key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_cfg_valid && o_cfg_ready;
        end
    end

    aes_key_sched u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   ({r_key_high, r_key_low}),
        .o_rk    (rk)
    );

    // Input stage: capture the block and apply the initial round key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_state <= {i_block_high, i_block_low} ^ rk[0];
    end

    assign v[0]  = r_in_valid;
    assign st[0] = r_in_state;

    for (genvar g = 1; g <= aes_pkg::NUM_ROUNDS; g++) begin : g_round
        aes_round_stage u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g - 1]),
            .i_state (st[g - 1]),
            .i_rk    (rk[g]),
            .i_mix   (g != aes_pkg::NUM_ROUNDS),
            .o_valid (v[g]),
            .o_state (st[g])
        );
    end

    // Output register: present each item for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= v[aes_pkg::NUM_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= st[aes_pkg::NUM_ROUNDS];
    end

    assign o_done        = r_done;
    assign o_cipher_high = r_out[127:64];
    assign o_cipher_low  = r_out[63:0];

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##12 o_done) else $error("item lost in pipeline");
    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_start && !o_busy) && $past(i_rst_n, 12)) |-> ##12 !o_done)
        else $error("result without item");
    a_last_stage_feeds_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[aes_pkg::NUM_ROUNDS] |=> o_done) else $error("final stage item dropped");
endmodule
`default_nettype wire

// ===== sim/tb_aes128_block_encrypt_core.sv =====
// Self-checking testbench for the AES-128 ECB encryption pipeline top level.
// Depends on aes128_block_encrypt_core and the aes_pkg package it compiles with.
`timescale 1ns / 100ps
`default_nettype none
module tb_aes128_block_encrypt_core;

    localparam int SETTLE_CYCLES = 16;   // time for the round keys to settle after a write
    localparam int STALL_LIMIT   = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        o_done;
    logic [63:0] o_cipher_high;
    logic [63:0] o_cipher_low;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    aes128_block_encrypt_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_block_high  (i_block_high),
        .i_block_low   (i_block_low),
        .o_done        (o_done),
        .o_cipher_high (o_cipher_high),
        .o_cipher_low  (o_cipher_low),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } t_cipher;

    t_cipher     cipher_q [$];        // expected ciphertexts, oldest first
    logic [63:0] key_hi_m, key_lo_m;  // key as the block should hold it
    logic [7:0]  sub_tab [256];
    int          errors;
    int          quiet_cycles;
    bit          gaps_on;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic logic [7:0] xtime(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = xtime(a);
        end
        return p;
    endfunction

    // Substitution table from its definition: inverse in GF(2^8), then affine map.
    function automatic void build_sub_tab();
        logic [7:0] inv, x;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h01;
            for (int e = 0; e < 254; e++) inv = gmul(inv, 8'(a));
            if (a == 0) inv = 8'h00;
            x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_tab[a] = x;
        end
    endfunction

    function automatic logic [7:0] byte_at(logic [127:0] v, int k);
        return v[127 - 8 * k -: 8];
    endfunction

    function automatic t_cipher predict_cipher(logic [127:0] key, logic [127:0] pt);
        logic [127:0] rk, st, nx;
        logic [31:0]  w, t;
        logic [7:0]   rcon, a0, a1, a2, a3, all;
        t_cipher      res;
        rk   = key;
        st   = pt ^ rk;
        rcon = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            // next round key
            w = rk[31:0];
            t = {sub_tab[w[23:16]] ^ rcon, sub_tab[w[15:8]], sub_tab[w[7:0]],
                 sub_tab[w[31:24]]};
            rk[127:96] ^= t;
            rk[95:64]  ^= rk[127:96];
            rk[63:32]  ^= rk[95:64];
            rk[31:0]   ^= rk[63:32];
            rcon = xtime(rcon);
            // substitute and shift rows
            for (int c = 0; c < 4; c++)
                for (int rw = 0; rw < 4; rw++)
                    nx[127 - 8 * (c * 4 + rw) -: 8] =
                        sub_tab[byte_at(st, ((c + rw) % 4) * 4 + rw)];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = byte_at(nx, c * 4);
                    a1 = byte_at(nx, c * 4 + 1);
                    a2 = byte_at(nx, c * 4 + 2);
                    a3 = byte_at(nx, c * 4 + 3);
                    all = a0 ^ a1 ^ a2 ^ a3;
                    nx[127 - 8 * (c * 4) -: 8]     = a0 ^ all ^ xtime(a0 ^ a1);
                    nx[127 - 8 * (c * 4 + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
                    nx[127 - 8 * (c * 4 + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
                    nx[127 - 8 * (c * 4 + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
                end
            end
            st = nx ^ rk;
        end
        res.high = st[127:64];
        res.low  = st[63:0];
        return res;
    endfunction

    // ---------------- reporting and checking ----------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s at %0t: got %h want %h", what, $time, got, want);
        errors++;
    endtask

    // Compare each ciphertext with the oldest expectation; a result with none pending is an error.
    always @(posedge i_clk) begin
        t_cipher want;
        if (i_rst_n && o_done) begin
            if (cipher_q.size() == 0) begin
                report_mismatch("unexpected result", o_cipher_high, o_cipher_low);
            end else begin
                want = cipher_q.pop_front();
                if (o_cipher_high !== want.high)
                    report_mismatch("cipher_high", o_cipher_high, want.high);
                if (o_cipher_low !== want.low)
                    report_mismatch("cipher_low", o_cipher_low, want.low);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    // Send one block, after a random gap when gaps are on; keep start high across back-to-back items.
    task automatic send_block(logic [63:0] hi, logic [63:0] lo);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_block_high <= hi;
        i_block_low  <= lo;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        cipher_q.push_back(predict_cipher({key_hi_m, key_lo_m}, {hi, lo}));
    endtask

    // Drop start and hold until every expected ciphertext is back.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key(logic [63:0] hi, logic [63:0] lo);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= aes_pkg::CFG_KEY_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        key_hi_m = hi;
        i_cfg_index <= aes_pkg::CFG_KEY_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        key_lo_m = lo;
        i_cfg_valid <= 1'b0;
        // let the key schedule settle before the next block
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_key();
        // reset key of zero, extreme blocks
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h8000_0000_0000_0000, 64'h1);
    endtask

    task automatic test_known_vectors();
        write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    endtask

    task automatic test_key_extremes();
        write_key('1, '1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        for (int i = 0; i < 4; i++)
            send_block(64'h1 << (i * 21), 64'h8000_0000_0000_0000 >> (i * 19));
        write_key(64'h0, '1);
        send_block('1, 64'h0);
        send_block(64'h0, '1);
        write_key('1, 64'h0);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    endtask

    task automatic test_random_keys(int phases, int per_phase);
        logic [63:0] hi, lo;
        for (int p = 0; p < phases; p++) begin
            write_key(rand64(), rand64());
            for (int n = 0; n < per_phase; n++) begin
                case ($urandom_range(0, 7))
                    0: begin hi = 64'h1 << $urandom_range(0, 63); lo = 64'h0; end
                    1: begin hi = ~(64'h1 << $urandom_range(0, 63)); lo = '1; end
                    default: begin hi = rand64(); lo = rand64(); end
                endcase
                send_block(hi, lo);
                if (p == 1 && n == per_phase / 2) drain();   // pause until all are back
            end
        end
    endtask

    task automatic test_full_rate(int count);
        gaps_on = 1'b0;
        write_key(rand64(), rand64());
        for (int n = 0; n < count; n++) send_block(rand64(), rand64());
    endtask

    initial begin
        errors       = 0;
        gaps_on      = 1'b1;
        key_hi_m     = 64'h0;
        key_lo_m     = 64'h0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_block_high = '0;
        i_block_low  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = aes_pkg::CFG_KEY_HIGH;
        i_cfg_data   = '0;
        build_sub_tab();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_reset_key();
        test_known_vectors();
        test_key_extremes();
        test_random_keys(6, 280);
        test_full_rate(250);

        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
design/aes_pkg.sv
design/aes_key_sched.sv
design/aes_round_stage.sv
design/aes128_block_encrypt_core.sv
sim/tb_aes128_block_encrypt_core.sv
